[hdl/software_timer_bank_assert.svh]
// assertion macros of the timer bank checker
`ifndef SOFTWARE_TIMER_BANK_ASSERT_SVH
`define SOFTWARE_TIMER_BANK_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define STB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define STB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/stb_pkg.sv]
// shared types and constants of the software timer bank
package stb_pkg;

   localparam int NUM_TIMERS_DEF = 8;
   localparam int CMD_W  = 3;
   localparam int ID_W   = 3;
   localparam int PMS_W  = 32;
   localparam int TPM_W  = 10;
   localparam int TICK_W = 32;
   localparam int PROD_W = PMS_W + TPM_W;
   localparam int REQ_DATA_W = ((ID_W + PMS_W + 1 + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((ID_W + 2 + 7) / 8) * 8;

   localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(1);

   // mode value of a one-shot timer
   localparam logic MODE_ONE_SHOT = 1'b0;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_EVENT  = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 3'd0,
      CMD_CREATE = 3'd1,
      CMD_START  = 3'd2,
      CMD_STOP   = 3'd3,
      CMD_DELETE = 3'd4,
      CMD_QUERY  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic exec;
      logic scan_adv;
      logic flush;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic req_is_tick;
      logic out_free;
      logic stall;
      logic scan_done;
      logic pend_valid;
   } stat_type;

endpackage

[hdl/software_timer_bank.sv]
// top level of the software timer bank
//
// A bank of NUM_TIMERS one-shot or periodic timers driven by command beats on the
// req stream (tick, create, start, stop, delete, query). Every command other than
// tick returns exactly one status beat with tlast set; a tick advances the 32-bit
// wrapping time base and returns one expiry beat per expired timer in ascending
// index order, tlast on the last one, and nothing when no timer expires. A timer
// expires when the elapsed ticks since its start exceed its period strictly;
// start converts period_ms to ticks with the csr ticks-per-ms value, saturating at
// 32 bits. Timing: a non-tick command passes through accept and execute; a tick
// scans the entries in turn, because the start tick and period memories have a
// single read port and the scan checks one entry per cycle; both are held while
// the rsp side stalls. A result beat waits in an output register while the
// next command beat is already taken. Write the csr only while the bank is idle.
module software_timer_bank #(
   parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // command stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [2:0] timer_id, [34:3] period_ms, [35] periodic, [39:36] zero
   input  logic [stb_pkg::REQ_DATA_W-1:0] req_tdata,
   // [2:0] command
   input  logic [stb_pkg::CMD_W-1:0]      req_tuser,
   // result stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [2:0] which_timer, [3] ok, [4] is_running, [7:5] zero
   output logic [stb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] kind: status or expiry event
   output logic                           rsp_tuser,
   output logic                           rsp_tlast,
   // ticks per millisecond register
   input  logic                           csr_we,
   input  logic [stb_pkg::TPM_W-1:0]      csr_wdata
);
   import stb_pkg::*;

   ctl_type          ctl;
   stat_type         st;
   logic [ID_W-1:0]  rsp_which;
   logic             rsp_ok;
   logic             rsp_running;

   // sequencer: idle, execute a command, scan on tick, flush the held expiry
   stb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .ctl        (ctl)
   );

   // timer flags, memories, expiry compare and output register
   stb_dpath #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .st            (st),
      .req_command   (req_tuser),
      .req_timer_id  (req_tdata[ID_W-1:0]),
      .req_period_ms (req_tdata[ID_W+PMS_W-1:ID_W]),
      .req_periodic  (req_tdata[ID_W+PMS_W]),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_kind      (rsp_tuser),
      .rsp_which     (rsp_which),
      .rsp_ok        (rsp_ok),
      .rsp_running   (rsp_running),
      .rsp_last      (rsp_tlast)
   );

   // pack result fields, upper bits zero
   assign rsp_tdata = RSP_DATA_W'({rsp_running, rsp_ok, rsp_which});

endmodule

[hdl/stb_ctrl.sv]
// command sequencer of the timer bank
module stb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  stb_pkg::stat_type st,
   output stb_pkg::ctl_type  ctl
);
   import stb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = st.req_is_tick ? ST_SCAN : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (st.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (st.scan_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!st.pend_valid || st.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      ctl          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ctl.accept = req_tvalid;
         end
         ST_EXEC: begin
            ctl.exec = st.out_free;
         end
         ST_SCAN: begin
            ctl.scan_adv = !st.stall;
         end
         ST_FLUSH: begin
            ctl.flush = st.pend_valid && st.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

[hdl/stb_dpath.sv]
// timer state, entry memories, expiry check and result register
module stb_dpath #(
   parameter int NUM_TIMERS = stb_pkg::NUM_TIMERS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  stb_pkg::ctl_type           ctl,
   output stb_pkg::stat_type          st,
   input  logic [stb_pkg::CMD_W-1:0]  req_command,
   input  logic [stb_pkg::ID_W-1:0]   req_timer_id,
   input  logic [stb_pkg::PMS_W-1:0]  req_period_ms,
   input  logic                       req_periodic,
   input  logic                       csr_we,
   input  logic [stb_pkg::TPM_W-1:0]  csr_wdata,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_kind,
   output logic [stb_pkg::ID_W-1:0]   rsp_which,
   output logic                       rsp_ok,
   output logic                       rsp_running,
   output logic                       rsp_last
);
   import stb_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);

   // configuration and time base
   logic [TPM_W-1:0]      tpm_ff;
   logic [TICK_W-1:0]     now_ff, now_in;

   // per-timer flags
   logic [NUM_TIMERS-1:0] running_ff, running_in;
   logic [NUM_TIMERS-1:0] created_ff, created_in;
   logic [NUM_TIMERS-1:0] periodic_ff, periodic_in;

   // entry memories
   logic [TICK_W-1:0]     start_mem  [NUM_TIMERS];
   logic [TICK_W-1:0]     period_mem [NUM_TIMERS];
   logic [TICK_W-1:0]     rd_start_ff, rd_period_ff;

   // latched command
   logic [CMD_W-1:0]      cmd_ff;
   logic [ID_W-1:0]       id_ff;
   logic [PMS_W-1:0]      pms_ff;
   logic                  per_ff;
   logic [PROD_W-1:0]     prod_ff;

   // scan pipeline
   logic [CNT_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic                  ev_valid_ff, ev_valid_in;
   logic [IDX_W-1:0]      ev_idx_ff;
   logic                  pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic                  pend_run_ff, pend_run_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]       rsp_which_ff, rsp_which_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic                  rsp_run_ff, rsp_run_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  req_is_tick;
   logic                  id_ok;
   logic [IDX_W-1:0]      id_idx;
   logic                  cur_run;
   logic                  start_go;
   logic [TICK_W-1:0]     sat_period;
   logic                  exec_ok;
   logic                  exec_run;
   logic                  rd_go;
   logic [IDX_W-1:0]      rd_idx;
   logic                  rd_step;
   logic [TICK_W-1:0]     elapsed;
   logic                  expire;
   logic                  ev_once;
   logic                  scan_fire;
   logic                  push_mid;
   logic                  load;
   logic [IDX_W-1:0]      mem_addr;
   logic                  we_start;
   logic                  we_period;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_is_tick = (req_command == CMD_TICK);

   assign id_ok   = (int'(id_ff) < NUM_TIMERS);
   assign id_idx  = IDX_W'(id_ff);
   assign cur_run = id_ok && running_ff[id_idx];
   assign start_go = ctl.exec && id_ok && (cmd_ff == CMD_START) &&
                     (pms_ff != '0) && !cur_run;
   assign sat_period = (|prod_ff[PROD_W-1:TICK_W]) ? '1 : prod_ff[TICK_W-1:0];

   assign rd_go   = (rd_cnt_ff < CNT_W'(NUM_TIMERS));
   assign rd_idx  = rd_cnt_ff[IDX_W-1:0];
   assign rd_step = ctl.scan_adv && rd_go;

   assign elapsed = now_ff - rd_start_ff;
   assign expire  = ev_valid_ff && running_ff[ev_idx_ff] && created_ff[ev_idx_ff] &&
                    (elapsed > rd_period_ff);
   assign ev_once   = (periodic_ff[ev_idx_ff] == MODE_ONE_SHOT);
   assign scan_fire = ctl.scan_adv && expire;
   assign push_mid  = scan_fire && pend_valid_ff;
   assign load      = ctl.exec || push_mid || ctl.flush;

   assign mem_addr  = ctl.exec ? id_idx : ev_idx_ff;
   assign we_start  = start_go || (scan_fire && !ev_once);
   assign we_period = start_go;

   assign st.req_is_tick = req_is_tick;
   assign st.out_free    = out_free;
   assign st.stall       = expire && pend_valid_ff && !out_free;
   assign st.scan_done   = !ev_valid_ff && !rd_go;
   assign st.pend_valid  = pend_valid_ff;

   // flag updates from commands and expiries
   always_comb begin
      running_in  = running_ff;
      created_in  = created_ff;
      periodic_in = periodic_ff;
      if (ctl.exec && id_ok) begin
         case (cmd_ff)
            CMD_CREATE: begin
               if (!cur_run) begin
                  periodic_in[id_idx] = per_ff;
                  created_in[id_idx]  = 1'b1;
               end
            end
            CMD_START: begin
               if (start_go) begin
                  running_in[id_idx] = 1'b1;
               end
            end
            CMD_STOP, CMD_DELETE: begin
               running_in[id_idx] = 1'b0;
            end
            default: begin
               running_in = running_ff;
            end
         endcase
      end
      if (scan_fire && ev_once) begin
         running_in[ev_idx_ff] = 1'b0;
      end
   end

   always_comb begin
      exec_ok = 1'b0;
      if (id_ok) begin
         case (cmd_ff)
            CMD_CREATE:           exec_ok = 1'b1;
            CMD_START:            exec_ok = (pms_ff != '0) && !cur_run;
            CMD_STOP, CMD_DELETE: exec_ok = cur_run;
            CMD_QUERY:            exec_ok = 1'b1;
            default:              exec_ok = 1'b0;
         endcase
      end
      exec_run = id_ok && running_in[id_idx];
   end

   always_comb begin
      now_in      = now_ff;
      rd_cnt_in   = rd_cnt_ff;
      ev_valid_in = ev_valid_ff;
      if (ctl.accept && req_is_tick) begin
         now_in      = now_ff + TICK_W'(1);
         rd_cnt_in   = '0;
         ev_valid_in = 1'b0;
      end else if (ctl.scan_adv) begin
         ev_valid_in = rd_go;
         if (rd_go) begin
            rd_cnt_in = rd_cnt_ff + CNT_W'(1);
         end
      end
   end

   // one expiry is held back until the next one or the end of the scan
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_run_in   = pend_run_ff;
      if (scan_fire) begin
         pend_valid_in = 1'b1;
         pend_idx_in   = ev_idx_ff;
         pend_run_in   = !ev_once;
      end else if (ctl.flush || ctl.accept) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_which_in = rsp_which_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
      if (ctl.exec) begin
         rsp_kind_in  = KIND_STATUS;
         rsp_which_in = id_ff;
         rsp_ok_in    = exec_ok;
         rsp_run_in   = exec_run;
         rsp_last_in  = 1'b1;
      end else if (push_mid || ctl.flush) begin
         rsp_kind_in  = KIND_EVENT;
         rsp_which_in = ID_W'(pend_idx_ff);
         rsp_ok_in    = 1'b1;
         rsp_run_in   = pend_run_ff;
         rsp_last_in  = ctl.flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpm_ff        <= TPM_RESET;
         now_ff        <= '0;
         running_ff    <= '0;
         created_ff    <= '0;
         periodic_ff   <= '0;
         rd_cnt_ff     <= '0;
         ev_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            tpm_ff <= csr_wdata;
         end
         now_ff        <= now_in;
         running_ff    <= running_in;
         created_ff    <= created_in;
         periodic_ff   <= periodic_in;
         rd_cnt_ff     <= rd_cnt_in;
         ev_valid_ff   <= ev_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff  <= req_command;
         id_ff   <= req_timer_id;
         pms_ff  <= req_period_ms;
         per_ff  <= req_periodic;
         prod_ff <= PROD_W'(req_period_ms) * PROD_W'(tpm_ff);
      end
      if (rd_step) begin
         ev_idx_ff <= rd_idx;
      end
      pend_idx_ff  <= pend_idx_in;
      pend_run_ff  <= pend_run_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_which_ff <= rsp_which_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_run_ff   <= rsp_run_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // start tick and period memories, one write and one read port
   always_ff @(posedge clock) begin
      if (we_start) begin
         start_mem[mem_addr] <= now_ff;
      end
      if (we_period) begin
         period_mem[mem_addr] <= sat_period;
      end
      if (rd_step) begin
         rd_start_ff  <= start_mem[rd_idx];
         rd_period_ff <= period_mem[rd_idx];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_which   = rsp_which_ff;
   assign rsp_ok      = rsp_ok_ff;
   assign rsp_running = rsp_run_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

[hdl/stb_checker.sv]
// port-level checks of the timer bank and their bind
`include "software_timer_bank_assert.svh"

module stb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // a stalled result beat holds
   `STB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled rsp beat changed")

   // a status beat is always the only result of its command
   `STB_ASSERT_IMP(a_status_last, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast, "status beat without tlast")

   // expiry events always report success
   `STB_ASSERT_IMP(a_event_ok, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[3], "expiry beat with ok low")

   // one command at a time: ready drops after each accepted beat
   `STB_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "req_tready high after accept")

endmodule

bind software_timer_bank stb_checker u_stb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[bench/tb_software_timer_bank.sv]
// self-checking testbench of the software timer bank
`timescale 1ns / 1ps

module tb_software_timer_bank;
   import stb_pkg::*;

   localparam int NUM_TIMERS = NUM_TIMERS_DEF;
   // a tick scans every entry once, plus time for the pipeline and output register
   localparam int SETTLE_CYCLES = NUM_TIMERS + 8;
   // cycles with no beat on either side before the run is declared hung
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ITEMS_PER_PHASE = 16;

   // command codes the bank does not know, both answered with a failed status
   localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;

   // one command waiting for the driver
   typedef struct packed {
      logic [CMD_W-1:0] op;
      bit [ID_W-1:0]    id;
      bit [PMS_W-1:0]   period_ms;
      bit               periodic;
   } timer_command;

   // one result beat as the bank should produce it
   typedef struct packed {
      logic          kind;
      bit [ID_W-1:0] which;
      bit            ok;
      bit            running;
      bit            last;
   } timer_result;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [TPM_W-1:0] csr_wdata = '0;

   software_timer_bank #(.NUM_TIMERS(NUM_TIMERS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // commands not yet handed to the bank, and beats the bank still owes
   timer_command pending_cmds[$];
   timer_result  expected_beats[$];

   // shadow copy of the bank state
   bit [TICK_W-1:0] now_tick;
   bit [TPM_W-1:0]  rate_tpm;
   bit              run_q[NUM_TIMERS];
   bit              made_q[NUM_TIMERS];
   bit              periodic_q[NUM_TIMERS];
   bit [TICK_W-1:0] started_at[NUM_TIMERS];
   bit [TICK_W-1:0] period_ticks[NUM_TIMERS];

   int  fail_count = 0;
   int  quiet_cycles = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  steady_flow = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // apply one accepted command to the shadow state and queue the beats it causes
   function automatic void timer_bank_step(input logic [CMD_W-1:0] op, input bit [ID_W-1:0] id,
                                           input bit [PMS_W-1:0] pms, input bit per);
      bit [NUM_TIMERS-1:0] hit;
      bit [63:0]           product;
      bit                  okay;
      hit = '0;
      okay = 1'b0;
      if (op == CMD_TICK) begin
         now_tick = now_tick + 1;
         // decide every expiry first so the last flag is known when pushing
         for (int i = 0; i < NUM_TIMERS; i++)
            hit[i] = run_q[i] && made_q[i] && ((now_tick - started_at[i]) > period_ticks[i]);
         for (int i = 0; i < NUM_TIMERS; i++) begin
            if (hit[i]) begin
               if (periodic_q[i])
                  started_at[i] = now_tick;
               else
                  run_q[i] = 1'b0;
               expected_beats.push_back('{KIND_EVENT, 3'(i), 1'b1, run_q[i],
                                          (hit >> (i + 1)) == 0});
            end
         end
         return;
      end
      case (op)
         CMD_CREATE: begin
            // a running timer keeps its mode, but create still reports success
            if (!run_q[id]) begin
               periodic_q[id] = per;
               made_q[id] = 1'b1;
            end
            okay = 1'b1;
         end
         CMD_START: begin
            if (pms != 0 && !run_q[id]) begin
               product = 64'(pms) * 64'(rate_tpm);
               period_ticks[id] = (product > 64'hFFFF_FFFF) ? '1 : product[31:0];
               started_at[id] = now_tick;
               run_q[id] = 1'b1;
               okay = 1'b1;
            end
         end
         CMD_STOP, CMD_DELETE: begin
            if (run_q[id]) begin
               run_q[id] = 1'b0;
               okay = 1'b1;
            end
         end
         CMD_QUERY: okay = 1'b1;
         default: okay = 1'b0;
      endcase
      expected_beats.push_back('{KIND_STATUS, id, okay, run_q[id], 1'b1});
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // driver: hands out queued commands, with random idle bursts unless the flow is steady
   always @(posedge clock) begin
      timer_command item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() != 0 && !steady_flow && $urandom_range(0, 4) == 0) begin
            // this cycle idles too, on top of the random gap
            send_gap <= $urandom_range(0, 4);
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            item = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= item.op;
            req_tdata <= REQ_DATA_W'({item.periodic, item.period_ms, item.id});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side back pressure in random bursts
   always @(posedge clock) begin
      if (reset || steady_flow) begin
         rsp_tready <= !reset;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: checks result beats against the oldest expectation, then predicts from accepted
   // command beats and tracks csr writes
   always @(posedge clock) begin
      timer_result want;
      if (reset) begin
         now_tick = '0;
         rate_tpm = TPM_RESET;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            run_q[i] = 1'b0;
            made_q[i] = 1'b0;
            periodic_q[i] = 1'b0;
            started_at[i] = '0;
            period_ticks[i] = '0;
         end
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_beats.size() == 0) begin
               $error("result beat with nothing expected: kind %0d timer %0d",
                      rsp_tuser, rsp_tdata[2:0]);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               check_field("kind", want.kind, rsp_tuser);
               check_field("which_timer", want.which, rsp_tdata[2:0]);
               check_field("ok", want.ok, rsp_tdata[3]);
               check_field("is_running", want.running, rsp_tdata[4]);
               check_field("last", want.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready)
            timer_bank_step(req_tuser, req_tdata[2:0], req_tdata[34:3], req_tdata[35]);
         if (csr_we)
            rate_tpm = csr_wdata;
      end
   end

   // watchdog: no beat on either side for too long means the bank hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("software_timer_bank test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_command(input logic [CMD_W-1:0] op, input bit [ID_W-1:0] id,
                                input bit [PMS_W-1:0] pms, input bit per);
      pending_cmds.push_back('{op, id, pms, per});
   endtask

   // random command mix: plenty of ticks and starts so timers actually expire
   task automatic queue_random_command();
      int               pick;
      logic [CMD_W-1:0] op;
      bit [PMS_W-1:0]   pms;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         op = CMD_TICK;
      else if (pick < 55)
         op = CMD_CREATE;
      else if (pick < 75)
         op = CMD_START;
      else if (pick < 83)
         op = CMD_STOP;
      else if (pick < 89)
         op = CMD_DELETE;
      else if (pick < 96)
         op = CMD_QUERY;
      else
         op = $urandom_range(0, 1) ? CMD_UNKNOWN_HI : CMD_UNKNOWN_LO;
      case ($urandom_range(0, 9))
         0: pms = $urandom;
         1: pms = '1;
         2: pms = '0;
         default: pms = $urandom_range(1, 4);
      endcase
      queue_command(op, 3'($urandom_range(0, 7)), pms, 1'($urandom_range(0, 1)));
   endtask

   // wait for the bank to go idle: nothing left to send, nothing owed, scan finished
   task automatic drain_bank();
      while (pending_cmds.size() != 0 || req_tvalid || expected_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rate(input bit [TPM_W-1:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      bit [TPM_W-1:0] rates[5];
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, reset rate of one tick per ms
      queue_command(CMD_QUERY, 0, 0, 0);
      queue_command(CMD_STOP, 0, 0, 0);              // stop of an idle timer fails
      queue_command(CMD_START, 0, 0, 0);             // zero period fails
      queue_command(CMD_CREATE, 0, 0, 1'b1);
      queue_command(CMD_START, 0, 1, 0);
      queue_command(CMD_START, 0, 1, 0);             // already running
      queue_command(CMD_CREATE, 1, 0, MODE_ONE_SHOT);
      queue_command(CMD_START, 1, 1, 0);
      queue_command(CMD_START, 2, '1, 0);            // start before create, longest period
      queue_command(CMD_TICK, 0, 0, 0);
      queue_command(CMD_TICK, 0, 0, 0);              // periodic and one-shot both expire
      queue_command(CMD_TICK, 0, 0, 0);
      queue_command(CMD_UNKNOWN_LO, 0, 0, 0);
      queue_command(CMD_UNKNOWN_HI, 2, 0, 0);
      queue_command(CMD_STOP, 0, 0, 0);
      drain_bank();

      // zero rate: every running timer fires on each tick, all eight at once on the first
      write_rate('0);
      queue_command(CMD_DELETE, 2, 0, 0);
      for (int i = 2; i < NUM_TIMERS; i++)
         queue_command(CMD_CREATE, 3'(i), 0, 1'b1);
      for (int i = 0; i < NUM_TIMERS; i++)
         queue_command(CMD_START, 3'(i), $urandom | 32'd1, 0);
      queue_command(CMD_TICK, 0, 0, 0);
      queue_command(CMD_TICK, 0, 0, 0);
      drain_bank();

      // random phases, each at its own rate; the sender holds off between them
      rates[0] = '1;
      rates[1] = 10'd1000;
      rates[2] = 10'($urandom_range(1, 1000));
      rates[3] = 10'd1;
      rates[4] = 10'($urandom_range(0, 1023));
      for (int p = 0; p < 5; p++) begin
         // no idling at all in the last phase
         if (p == 4)
            steady_flow = 1'b1;
         write_rate(rates[p]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            queue_random_command();
         drain_bank();
      end

      if (fail_count == 0)
         $display("software_timer_bank test passed");
      else
         $display("software_timer_bank test failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/stb_pkg.sv
hdl/stb_ctrl.sv
hdl/stb_dpath.sv
hdl/software_timer_bank.sv
hdl/stb_checker.sv
bench/tb_software_timer_bank.sv
